[hw/rtl/q15fir_pkg.sv]
// Shared types, constants and codes for the Q15 FIR filter core.
// No dependencies; imported by every module of the core.
`default_nettype none
package q15fir_pkg;

  // Filter geometry
  localparam int MAX_TAPS   = 64;
  localparam int TAP_IDX_W  = $clog2(MAX_TAPS);
  localparam int TAP_CNT_W  = $clog2(MAX_TAPS + 1);
  localparam int TAP_CFG_W  = 7;
  localparam int CMP_W      = TAP_CNT_W + TAP_CFG_W;

  // Data path widths
  localparam int SAMPLE_W   = 16;
  localparam int COEFF_W    = 16;
  localparam int CIDX_W     = 6;
  localparam int PROD_W     = SAMPLE_W + COEFF_W;
  localparam int ACC_W      = PROD_W + TAP_IDX_W + 1;
  localparam int COEFF_SHIFT = 15;
  localparam int Q_W        = ACC_W - COEFF_SHIFT;

  localparam logic [TAP_CFG_W-1:0] TAP_COUNT_RESET = TAP_CFG_W'(15);

  // Request kinds carried on s_tuser
  localparam logic ACT_FILTER = 1'b0;
  localparam logic ACT_LOAD   = 1'b1;

  // Register map
  localparam logic REG_TAP_COUNT = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } fsm_state_t;

  typedef struct packed {
    logic shift;
    logic rotate;
  } cell_ctl_t;

  typedef struct packed {
    logic                 clear;
    logic                 rd_en;
    logic [TAP_IDX_W-1:0] rd_addr;
    logic                 wr_en;
    logic [TAP_IDX_W-1:0] wr_addr;
  } mac_ctl_t;

endpackage
`default_nettype wire

[hw/rtl/q15_fir_filter_saturating_core.sv]
// Top level of the Q15 FIR filter core: handshakes, register port, sequencer,
// delay-line cell chain. Depends on q15fir_pkg, q15fir_cell and q15fir_mac.
`default_nettype none
// Usage:
//   Requests enter on the s_* stream. s_tuser = 0 filters s_tdata's sample,
//   s_tuser = 1 loads coeff_value into coefficient slot coeff_index (no result).
//   Each filter request yields one result on the m_* stream: the Q15 sum,
//   shifted right 15 and clipped to 16 bits; m_tuser flags clipping.
//   tap_count (APB, address 0) picks how many taps are used; 0 acts as 1,
//   values above 64 act as 64. Write it only while the core is idle.
// Timing:
//   A load is written into coefficient slot coeff_index when it is taken. A
//   filter request shifts the sample into the 64-cell delay chain, then the
//   chain rotates once around while a single 16x16 multiplier fed from the
//   coefficient memory accumulates one tap per cycle (read, multiply, add).
//   The sequencer then waits in its drain state until the last taps have left
//   the multiply-accumulate stages and the output register is free, then loads
//   the result. One request at a time (s_tready high only when idle); the full
//   64-step rotation runs for every filter request, whatever the tap count.
// Stalls and reset:
//   The result sits in an output register; the next request is taken while
//   it waits. A finished sum waits until that register is free.
//   Synchronous reset clears the delay line and all coefficients (valid bits), tap_count=15.
module q15_fir_filter_saturating_core (
  input  wire        clk,
  input  wire        rst,
  // request stream
  input  wire        s_tvalid,
  output logic       s_tready,
  input  wire [39:0] s_tdata,   // [5:0] coeff_index, [21:6] coeff_value, [37:22] sample, pad
  input  wire        s_tuser,   // [0] action
  // result stream
  output logic       m_tvalid,
  input  wire        m_tready,
  output logic [15:0] m_tdata,  // [15:0] filtered_sample
  output logic       m_tuser,   // [0] saturated
  // register port
  input  wire        psel,
  input  wire        penable,
  input  wire        pwrite,
  input  wire [2:0]  paddr,
  input  wire [31:0] pwdata,
  output logic [31:0] prdata,
  output logic       pready
);
  import q15fir_pkg::*;

  // ---- request fields
  logic [CIDX_W-1:0]          coeff_index;
  logic signed [COEFF_W-1:0]  coeff_value;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       action;

  assign coeff_index = s_tdata[5:0];
  assign coeff_value = s_tdata[21:6];
  assign sample      = s_tdata[37:22];
  assign action      = s_tuser;

  // ---- register port: one register, always ready
  logic [TAP_CFG_W-1:0] tap_count;
  logic                 reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == REG_TAP_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count <= TAP_COUNT_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      tap_count <= pwdata[TAP_CFG_W-1:0];
    end
  end

  assign prdata = reg_sel ? 32'(tap_count) : '0;

  // effective tap count: clamp to 1..MAX_TAPS
  logic [CMP_W-1:0] taps_ext;
  logic [CMP_W-1:0] eff_taps;

  assign taps_ext = CMP_W'(tap_count);

  always_comb begin
    if (taps_ext == '0) begin
      eff_taps = CMP_W'(1);
    end else if (taps_ext > CMP_W'(MAX_TAPS)) begin
      eff_taps = CMP_W'(MAX_TAPS);
    end else begin
      eff_taps = taps_ext;
    end
  end

  // ---- sequencer
  fsm_state_t           state, state_next;
  logic [TAP_IDX_W-1:0] step, step_next;
  logic                 s_accept;
  logic                 filt_go;
  logic                 load_go;
  logic                 out_free;
  logic                 out_load;
  logic                 mac_busy;
  cell_ctl_t            cell_ctl;
  mac_ctl_t             mac_ctl;
  logic [CMP_W-1:0]     step_ext;
  logic [CMP_W-1:0]     rd_idx;
  logic [CMP_W-1:0]     wr_idx;

  assign s_accept = s_tvalid && s_tready;
  assign filt_go  = s_accept && (action == ACT_FILTER);
  assign load_go  = s_accept && (action == ACT_LOAD);
  assign out_free = !m_tvalid || m_tready;
  assign step_ext = CMP_W'(step);
  // newest sample pairs with coefficient taps-1, older ones walk down
  assign rd_idx   = eff_taps - CMP_W'(1) - step_ext;
  assign wr_idx   = CMP_W'(coeff_index);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next      = state;
    step_next       = step;
    s_tready        = 1'b0;
    out_load        = 1'b0;
    cell_ctl.shift  = 1'b0;
    cell_ctl.rotate = 1'b0;
    mac_ctl.clear   = 1'b0;
    mac_ctl.rd_en   = 1'b0;
    mac_ctl.rd_addr = rd_idx[TAP_IDX_W-1:0];
    mac_ctl.wr_en   = load_go && (wr_idx < CMP_W'(MAX_TAPS));
    mac_ctl.wr_addr = wr_idx[TAP_IDX_W-1:0];
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (filt_go) begin
          cell_ctl.shift = 1'b1;
          mac_ctl.clear  = 1'b1;
          step_next      = '0;
          state_next     = ST_RUN;
        end
      end
      ST_RUN: begin
        // full turn of the ring so the line ends where it started
        cell_ctl.rotate = 1'b1;
        mac_ctl.rd_en   = (step_ext < eff_taps);
        step_next       = step + TAP_IDX_W'(1);
        if (step == TAP_IDX_W'(MAX_TAPS - 1)) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!mac_busy && out_free) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // ---- delay-line chain
  logic [SAMPLE_W-1:0] delay [MAX_TAPS];

  for (genvar i = 0; i < MAX_TAPS; i++) begin : g_cell
    q15fir_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (cell_ctl),
      .shift_in ((i == 0) ? sample : delay[(i + MAX_TAPS - 1) % MAX_TAPS]),
      .rot_in   (delay[(i + 1) % MAX_TAPS]),
      .value    (delay[i])
    );
  end

  // ---- multiply-accumulate
  logic signed [ACC_W-1:0] acc;

  q15fir_mac u_mac (
    .clk     (clk),
    .rst     (rst),
    .ctl     (mac_ctl),
    .wr_data (coeff_value),
    .head    (delay[0]),
    .acc     (acc),
    .busy    (mac_busy)
  );

  // ---- scale and clip
  localparam logic signed [Q_W-1:0] Q_MAX = Q_W'(32767);
  localparam logic signed [Q_W-1:0] Q_MIN = Q_W'(-32768);

  logic signed [Q_W-1:0]      q;
  logic signed [SAMPLE_W-1:0] q_sat;
  logic                       q_clip;

  // arithmetic shift floors, as the spec rounds toward minus infinity
  assign q = Q_W'(acc >>> COEFF_SHIFT);

  always_comb begin
    if (q > Q_MAX) begin
      q_sat  = SAMPLE_W'(Q_MAX);
      q_clip = 1'b1;
    end else if (q < Q_MIN) begin
      q_sat  = SAMPLE_W'(Q_MIN);
      q_clip = 1'b1;
    end else begin
      q_sat  = SAMPLE_W'(q);
      q_clip = 1'b0;
    end
  end

  // ---- output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= q_sat;
      m_tuser <= q_clip;
    end
  end

`ifndef SYNTHESIS
  // an accepted sample lands in the head cell
  a_head_gets_sample: assert property (@(posedge clk) disable iff (rst)
    filt_go |=> (delay[0] == $past(sample)))
    else $error("core: sample not shifted in");
  // the rotation ends after exactly one turn of the ring
  a_run_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN && step == TAP_IDX_W'(MAX_TAPS - 1)) |=> (state == ST_DRAIN))
    else $error("core: rotation did not end");
  // a clipped result carries one of the two rail values
  a_clip_rail: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata == 16'h7fff || m_tdata == 16'h8000))
    else $error("core: clip flag without rail value");
  // a result is only loaded when the accumulator has settled
  a_load_settled: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!mac_busy && state == ST_DRAIN))
    else $error("core: result loaded early");
`endif

endmodule
`default_nettype wire

[hw/rtl/q15fir_cell.sv]
// One delay-line cell: holds one sample, shifts or rotates with its neighbors.
// Depends on q15fir_pkg.
`default_nettype none
module q15fir_cell (
  input  wire                            clk,
  input  wire                            rst,
  input  q15fir_pkg::cell_ctl_t          ctl,
  input  wire [q15fir_pkg::SAMPLE_W-1:0] shift_in,
  input  wire [q15fir_pkg::SAMPLE_W-1:0] rot_in,
  output logic [q15fir_pkg::SAMPLE_W-1:0] value
);
  import q15fir_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      value <= '0;
    end else if (ctl.shift) begin
      value <= shift_in;
    end else if (ctl.rotate) begin
      value <= rot_in;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/q15fir_mac.sv]
// Coefficient memory with per-entry valid bits and the shared multiply-accumulate.
// Depends on q15fir_pkg.
`default_nettype none
module q15fir_mac (
  input  wire                                clk,
  input  wire                                rst,
  input  q15fir_pkg::mac_ctl_t               ctl,
  input  wire signed [q15fir_pkg::COEFF_W-1:0]  wr_data,
  input  wire signed [q15fir_pkg::SAMPLE_W-1:0] head,
  output logic signed [q15fir_pkg::ACC_W-1:0]   acc,
  output logic                               busy
);
  import q15fir_pkg::*;

  logic [COEFF_W-1:0]         mem [MAX_TAPS];
  logic [MAX_TAPS-1:0]        coef_vld;
  logic signed [COEFF_W-1:0]  rd_data;
  logic signed [SAMPLE_W-1:0] head_q;
  logic                       s1_v;
  logic                       s1_ok;
  logic signed [PROD_W-1:0]   prod;
  logic                       s2_v;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.wr_addr] <= wr_data;
    end
    rd_data <= mem[ctl.rd_addr];
    head_q  <= head;
    prod    <= rd_data * head_q;
  end

  // unwritten entries act as zero: they simply skip the accumulate
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_vld <= '0;
      s1_v     <= 1'b0;
      s1_ok    <= 1'b0;
      s2_v     <= 1'b0;
      acc      <= '0;
    end else begin
      if (ctl.wr_en) begin
        coef_vld[ctl.wr_addr] <= 1'b1;
      end
      s1_v  <= ctl.rd_en;
      s1_ok <= ctl.rd_en & coef_vld[ctl.rd_addr];
      s2_v  <= s1_ok;
      if (ctl.clear) begin
        acc <= '0;
      end else if (s2_v) begin
        acc <= acc + ACC_W'(prod);
      end
    end
  end

  assign busy = s1_v | s2_v;

`ifndef SYNTHESIS
  // a product only enters the accumulator when its read was issued ahead of it through the s1 and s2 stages
  a_s2_follows_read: assert property (@(posedge clk) disable iff (rst)
    s2_v |-> $past(ctl.rd_en, 2))
    else $error("mac: product without read");
  // clearing never overlaps a tap still in flight
  a_clear_idle: assert property (@(posedge clk) disable iff (rst)
    ctl.clear |-> !busy)
    else $error("mac: clear while busy");
  // the accumulator holds when nothing reaches it
  a_acc_hold: assert property (@(posedge clk) disable iff (rst)
    (!s2_v && !ctl.clear) |=> $stable(acc))
    else $error("mac: accumulator changed while idle");
`endif

endmodule
`default_nettype wire

[tb/testbench.sv]
// Self-checking bench for q15_fir_filter_saturating_core: stream requests in,
// filtered samples out, tap count set over APB. Depends on q15fir_pkg.
`default_nettype none
module testbench;
  import q15fir_pkg::*;

  localparam int HALF_PERIOD  = 5;
  localparam int RESET_CYCLES = 8;
  localparam int IDLE_PCT     = 37;
  localparam int DRAIN_CYCLES = 80;    // tail padding that covers one filter pass
  localparam int STALL_LIMIT  = 3000;  // cycles with no transfer of any kind
  localparam int MAX_REPORTS  = 10;
  localparam int RAND_PHASES  = 10;
  localparam int PHASE_REQS   = 110;
  localparam logic [2:0] TAP_ADDR = 3'(4 * REG_TAP_COUNT);

  typedef struct {
    logic               act;
    logic [5:0]         idx;
    logic signed [15:0] cval;
    logic signed [15:0] smp;
  } fir_req_t;

  typedef struct {
    logic signed [15:0] y;
    logic               sat;
  } fir_out_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;   // [5:0] coeff_index, [21:6] coeff_value, [37:22] sample, pad
  logic        s_tuser = 1'b0; // [0] action
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;        // [15:0] filtered_sample
  logic        m_tuser;        // [0] saturated
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  q15_fir_filter_saturating_core u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #HALF_PERIOD clk = ~clk;

  // Model state: delay line (entry 0 newest), coefficients, tap register
  logic signed [15:0] dline    [MAX_TAPS];
  logic signed [15:0] coef_mem [MAX_TAPS];
  logic [TAP_CFG_W-1:0] tap_cfg = TAP_COUNT_RESET;

  fir_req_t pending_reqs[$];
  fir_out_t exp_outputs[$];

  int n_reqs = 0;
  int n_loads = 0;
  int n_outs = 0;
  int n_sat = 0;
  int n_mismatch = 0;
  int n_settings = 0;
  int stall_cnt = 0;
  bit quiet;

  initial begin
    for (int i = 0; i < MAX_TAPS; i++) begin
      dline[i]    = '0;
      coef_mem[i] = '0;
    end
  end

  // No idling on either side for a stretch of requests in the middle of the run
  assign quiet = (n_reqs >= 400) && (n_reqs < 560);

  task automatic note_mismatch(input string what);
    n_mismatch++;
    if (n_mismatch <= MAX_REPORTS)
      $display("mismatch at %0t: %s", $realtime, what);
  endtask

  // Advance the filter model by one accepted request
  task automatic fir_predict(input fir_req_t r);
    longint   acc;
    longint   q;
    int       taps;
    fir_out_t o;
    if (r.act == ACT_LOAD) begin
      if (int'(r.idx) < MAX_TAPS)
        coef_mem[r.idx] = r.cval;
    end else begin
      for (int k = MAX_TAPS - 1; k > 0; k--)
        dline[k] = dline[k-1];
      dline[0] = r.smp;
      if (tap_cfg == 0)
        taps = 1;
      else if (int'(tap_cfg) > MAX_TAPS)
        taps = MAX_TAPS;
      else
        taps = int'(tap_cfg);
      acc = 0;
      for (int k = 0; k < taps; k++)
        acc += longint'(coef_mem[taps-1-k]) * longint'(dline[k]);
      q = acc >>> COEFF_SHIFT;  // floor toward minus infinity
      o.sat = 1'b0;
      if (q > 32767) begin
        q = 32767;
        o.sat = 1'b1;
      end else if (q < -32768) begin
        q = -32768;
        o.sat = 1'b1;
      end
      o.y = q[15:0];
      exp_outputs.push_back(o);
    end
  endtask

  // Request driver: holds a request until taken, then maybe idles
  always @(posedge clk) begin : req_driver
    fir_req_t r;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (pending_reqs.size() != 0 && (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
        r = pending_reqs.pop_front();
        s_tvalid <= 1'b1;
        s_tuser  <= r.act;
        s_tdata  <= {2'b00, r.smp, r.cval, r.idx};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Result sink back-pressure
  always @(posedge clk) begin
    if (rst)
      m_tready <= 1'b0;
    else
      m_tready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Monitor: predicts on each accepted request, checks each accepted result
  always @(posedge clk) begin : monitor
    fir_req_t r;
    fir_out_t o;
    bit       moved;
    if (!rst) begin
      moved = 1'b0;
      if (s_tvalid && s_tready) begin
        r.act  = s_tuser;
        r.idx  = s_tdata[5:0];
        r.cval = s_tdata[21:6];
        r.smp  = s_tdata[37:22];
        fir_predict(r);
        n_reqs++;
        if (r.act == ACT_LOAD)
          n_loads++;
        moved = 1'b1;
      end
      if (m_tvalid && m_tready) begin
        moved = 1'b1;
        n_outs++;
        if (exp_outputs.size() == 0) begin
          note_mismatch($sformatf("unexpected result y=%0d sat=%0b",
                                  $signed(m_tdata), m_tuser));
        end else begin
          o = exp_outputs.pop_front();
          if (o.sat)
            n_sat++;
          if (m_tdata !== o.y || m_tuser !== o.sat)
            note_mismatch($sformatf("result %0d: expected y=%0d sat=%0b, got y=%0d sat=%0b",
                                    n_outs, o.y, o.sat, $signed(m_tdata), m_tuser));
        end
      end
      if (psel && penable && pwrite && pready) begin
        moved = 1'b1;
        if (paddr == TAP_ADDR)
          tap_cfg = pwdata[TAP_CFG_W-1:0];
      end
      stall_cnt = moved ? 0 : stall_cnt + 1;
      if (stall_cnt >= STALL_LIMIT) begin
        $display("timeout: no transfer for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, exp_outputs.size());
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic push_req(input logic act, input logic [5:0] idx,
                          input logic [15:0] cval, input logic [15:0] smp);
    fir_req_t r;
    r.act  = act;
    r.idx  = idx;
    r.cval = cval;
    r.smp  = smp;
    pending_reqs.push_back(r);
  endtask

  // Write tap_count, then read it back
  task automatic set_taps(input logic [TAP_CFG_W-1:0] v);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= TAP_ADDR;
    pwdata  <= 32'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== 32'(v))
      note_mismatch($sformatf("tap_count readback: expected %0d, got %0d", v, prdata));
    psel    <= 1'b0;
    penable <= 1'b0;
    n_settings++;
  endtask

  // Block is idle once queues are empty; loads leave no result, so pad the tail
  task automatic wait_drained();
    while (pending_reqs.size() != 0 || s_tvalid || exp_outputs.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Mostly full-range values, with the extremes weighted up
  function automatic logic [15:0] pick16();
    case ($urandom_range(0, 7))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'($urandom());
    endcase
  endfunction

  initial begin : stimulus
    logic [TAP_CFG_W-1:0] tap_plan [RAND_PHASES];
    tap_plan = '{7'd1, 7'd64, 7'd127, 7'd0, 7'd2, 7'd7, 7'd15, 7'd33, 7'd65, 7'd3};
    tap_plan[RAND_PHASES-1] = 7'($urandom_range(0, 127));

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Reset tap count (15): floor rounding, ignored fields, slot outside taps
    push_req(ACT_FILTER, 6'd0, 16'h0000, 16'h7FFF);
    push_req(ACT_LOAD, 6'd14, 16'h7FFF, 16'hA5A5);
    push_req(ACT_LOAD, 6'd13, 16'h8000, 16'h0000);
    push_req(ACT_LOAD, 6'd63, 16'h7FFF, 16'hFFFF);
    push_req(ACT_LOAD, 6'd0, 16'h0001, 16'h0000);
    push_req(ACT_FILTER, 6'd63, 16'hFFFF, 16'h7FFF);
    push_req(ACT_FILTER, 6'd0, 16'h0000, 16'h8000);
    push_req(ACT_FILTER, 6'd0, 16'h0000, 16'h0000);
    push_req(ACT_FILTER, 6'd0, 16'h0000, 16'hFFFF);
    push_req(ACT_FILTER, 6'd0, 16'h0000, 16'h0001);
    wait_drained();

    // One tap: most negative squared clips high
    set_taps(7'd1);
    push_req(ACT_LOAD, 6'd0, 16'h8000, 16'h0000);
    push_req(ACT_FILTER, 6'd0, 16'h0000, 16'h8000);
    push_req(ACT_FILTER, 6'd0, 16'h0000, 16'h7FFF);
    wait_drained();

    // Two taps: clips low
    set_taps(7'd2);
    push_req(ACT_LOAD, 6'd1, 16'h8000, 16'h0000);
    push_req(ACT_FILTER, 6'd0, 16'h0000, 16'h7FFF);
    push_req(ACT_FILTER, 6'd0, 16'h0000, 16'h7FFF);
    wait_drained();

    // Zero acts as one tap; above 64 acts as 64
    set_taps(7'd0);
    push_req(ACT_FILTER, 6'd0, 16'h0000, 16'h8000);
    push_req(ACT_FILTER, 6'd0, 16'h0000, 16'h0001);
    wait_drained();
    set_taps(7'd127);
    push_req(ACT_FILTER, 6'd0, 16'h0000, 16'h7FFF);
    wait_drained();
    set_taps(7'd64);
    push_req(ACT_FILTER, 6'd0, 16'h0000, 16'h8000);
    wait_drained();

    // Random phases, each under its own tap count; about one load in five
    for (int p = 0; p < RAND_PHASES; p++) begin
      set_taps(tap_plan[p]);
      for (int i = 0; i < PHASE_REQS; i++) begin
        if ($urandom_range(0, 99) < 20)
          push_req(ACT_LOAD, 6'($urandom_range(0, 63)), pick16(), 16'($urandom()));
        else
          push_req(ACT_FILTER, 6'($urandom()), 16'($urandom()), pick16());
      end
      wait_drained();
    end

    $display("covered %0d requests (%0d coefficient loads), %0d results checked",
             n_reqs, n_loads, n_outs);
    $display("%0d clipped results, %0d tap_count settings, %0d mismatches",
             n_sat, n_settings, n_mismatch);
    if (n_mismatch == 0 && exp_outputs.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
